// File: src/assert_macros.svh
// Assertion macros shared by the glyph pipeline RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define PTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define PTA_ASSERT_NEVER(label, cond, msg) \
  `PTA_ASSERT(label, !(cond), msg)

`endif

// File: src/pta_pkg.sv
// Shared types, constants and the ramp lookup for the glyph pipeline
`default_nettype none
package pta_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_THRESH = 2'd1
  } cfg_idx_t;

  localparam logic [11:0] GAIN_RESET   = 12'd256;
  localparam logic [11:0] THRESH_RESET = 12'd256;

  // Direction tangents, Q16
  localparam logic [14:0] TAN_LOW  = 15'd27146;
  localparam logic [17:0] TAN_HIGH = 18'd158218;

  // Rec.709 luma weights, Q16
  localparam logic [13:0] LUMA_R = 14'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [12:0] LUMA_B = 13'd4732;

  // One ramp step of luma: 255 * 65536 / 12
  localparam logic [20:0] LUMA_STEP  = 21'd1392640;
  localparam int          RAMP_LEN   = 12;

  // Edge glyphs
  localparam logic [6:0] CH_UNDER = 7'h5F;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CH_BACK  = 7'h5C;
  localparam logic [6:0] CH_BAR   = 7'h7C;

  // Stage 1: scaled colour, squared gradients, tangent products
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [22:0] gx_sq;
    logic [22:0] gy_sq;
    logic [23:0] thr_sq;
    logic [11:0] ay;
    logic [29:0] ax_tan_high;
    logic [26:0] ax_tan_low;
    logic        gx_pos;
    logic        gy_pos;
  } s1_t;

  // Stage 2: edge decision and luma partial products
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_edge;
    logic [6:0]  edge_glyph;
    logic [21:0] luma_r;
    logic [23:0] luma_g;
    logic [20:0] luma_b;
  } s2_t;

  // Stage 3: summed luma
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_edge;
    logic [6:0]  edge_glyph;
    logic [23:0] luma;
  } s3_t;

  // Ramp " .-=+*x#$&X@", dark to bright
  function automatic logic [6:0] ramp_char(input logic [3:0] idx);
    logic [6:0] ch;
    case (idx)
      4'd0:    ch = 7'h20;
      4'd1:    ch = 7'h2E;
      4'd2:    ch = 7'h2D;
      4'd3:    ch = 7'h3D;
      4'd4:    ch = 7'h2B;
      4'd5:    ch = 7'h2A;
      4'd6:    ch = 7'h78;
      4'd7:    ch = 7'h23;
      4'd8:    ch = 7'h24;
      4'd9:    ch = 7'h26;
      4'd10:   ch = 7'h58;
      default: ch = 7'h40;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: src/pta_in_if.sv
// Pixel input channel: colour plus producer gradients
`default_nettype none
interface pta_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        red_in;
  logic [7:0]        green_in;
  logic [7:0]        blue_in;
  logic signed [11:0] grad_horiz;
  logic signed [11:0] grad_vert;

  modport source (output valid, red_in, green_in, blue_in, grad_horiz, grad_vert,
                  input ready);
  modport sink   (input valid, red_in, green_in, blue_in, grad_horiz, grad_vert,
                  output ready);
endinterface
`default_nettype wire

// File: src/pta_out_if.sv
// Result channel: glyph code plus brightened colour
`default_nettype none
interface pta_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] glyph;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, glyph, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, glyph, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

// File: src/pta_front.sv
// Stage 1: colour gain, gradient squares and direction products
`default_nettype none
module pta_front import pta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pta_in_if.sink           in_pix,
  input  wire logic [11:0] gain,
  input  wire logic [11:0] thresh,
  output logic             s1_valid,
  output s1_t              s1_data,
  input  wire logic        s1_ready
);

  logic        valid_r;
  s1_t         data_r;
  s1_t         data_nxt;
  logic        load;
  logic [11:0] ax;
  logic [11:0] ay;
  logic signed [23:0] gx_sq_full;
  logic signed [23:0] gy_sq_full;

  // Gain in Q4.8, truncate, saturate at 255
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [11:0] g);
    logic [19:0] prod;
    prod = 20'(c) * 20'(g);
    return (|prod[19:16]) ? 8'hFF : prod[15:8];
  endfunction

  assign in_pix.ready = !valid_r || s1_ready;
  assign load         = in_pix.valid && in_pix.ready;

  // Stage 1 datapath
  always_comb begin
    ax = in_pix.grad_horiz[11] ? 12'(-in_pix.grad_horiz) : 12'(in_pix.grad_horiz);
    ay = in_pix.grad_vert[11]  ? 12'(-in_pix.grad_vert)  : 12'(in_pix.grad_vert);
    gx_sq_full = 24'(in_pix.grad_horiz) * 24'(in_pix.grad_horiz);
    gy_sq_full = 24'(in_pix.grad_vert) * 24'(in_pix.grad_vert);

    data_nxt.red         = scale_chan(in_pix.red_in, gain);
    data_nxt.green       = scale_chan(in_pix.green_in, gain);
    data_nxt.blue        = scale_chan(in_pix.blue_in, gain);
    data_nxt.gx_sq       = gx_sq_full[22:0];
    data_nxt.gy_sq       = gy_sq_full[22:0];
    data_nxt.thr_sq      = 24'(thresh) * 24'(thresh);
    data_nxt.ay          = ay;
    data_nxt.ax_tan_high = 30'(ax) * 30'(TAN_HIGH);
    data_nxt.ax_tan_low  = 27'(ax) * 27'(TAN_LOW);
    data_nxt.gx_pos      = !in_pix.grad_horiz[11] && (|in_pix.grad_horiz);
    data_nxt.gy_pos      = !in_pix.grad_vert[11] && (|in_pix.grad_vert);
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      valid_r <= in_pix.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule
`default_nettype wire

// File: src/pta_classify.sv
// Stages 2 and 3: edge test, direction, luma products and luma sum
`default_nettype none
module pta_classify import pta_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s1_valid,
  input  wire s1_t  s1_data,
  output logic      s1_ready,
  output logic      s3_valid,
  output s3_t       s3_data,
  input  wire logic s3_ready
);

  logic        s2_valid_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  logic        s2_ready;
  logic        s3_valid_r;
  s3_t         s3_r;
  s3_t         s3_nxt;
  logic        s3_in_ready;
  logic [23:0] mag_sq;
  logic [29:0] lhs;

  assign s3_in_ready = !s3_valid_r || s3_ready;
  assign s2_ready    = !s2_valid_r || s3_in_ready;
  assign s1_ready    = s2_ready;

  // Stage 2: magnitude test, sector choice, luma weights
  always_comb begin
    mag_sq = 24'(s1_data.gx_sq) + 24'(s1_data.gy_sq);
    lhs    = {2'b00, s1_data.ay, 16'd0};

    s2_nxt.red     = s1_data.red;
    s2_nxt.green   = s1_data.green;
    s2_nxt.blue    = s1_data.blue;
    s2_nxt.is_edge = mag_sq > s1_data.thr_sq;
    if (lhs > s1_data.ax_tan_high) begin
      s2_nxt.edge_glyph = CH_UNDER;
    end else if (lhs >= 30'(s1_data.ax_tan_low)) begin
      s2_nxt.edge_glyph = (s1_data.gx_pos == s1_data.gy_pos) ? CH_SLASH : CH_BACK;
    end else begin
      s2_nxt.edge_glyph = CH_BAR;
    end
    s2_nxt.luma_r = 22'(s1_data.red) * 22'(LUMA_R);
    s2_nxt.luma_g = 24'(s1_data.green) * 24'(LUMA_G);
    s2_nxt.luma_b = 21'(s1_data.blue) * 21'(LUMA_B);
  end

  // Stage 3: luma sum
  always_comb begin
    s3_nxt.red        = s2_r.red;
    s3_nxt.green      = s2_r.green;
    s3_nxt.blue       = s2_r.blue;
    s3_nxt.is_edge    = s2_r.is_edge;
    s3_nxt.edge_glyph = s2_r.edge_glyph;
    s3_nxt.luma       = 24'(s2_r.luma_r) + s2_r.luma_g + 24'(s2_r.luma_b);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (s3_in_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_r <= s2_nxt;
    end
    if (s2_valid_r && s3_in_ready) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_data  = s3_r;

endmodule
`default_nettype wire

// File: src/pta_glyph_out.sv
// Stage 4: ramp index, glyph choice and the output register
`default_nettype none
module pta_glyph_out import pta_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s3_valid,
  input  wire s3_t  s3_data,
  output logic      s3_ready,
  pta_out_if.source out_res
);

  logic       valid_r;
  logic [6:0] glyph_r;
  logic [6:0] glyph_nxt;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [3:0] idx;

  assign s3_ready = !valid_r || out_res.ready;

  // Ramp index: count the steps the luma has passed, top step clamps to the last
  always_comb begin
    idx = 4'd0;
    for (int k = 1; k < RAMP_LEN; k++) begin
      if (s3_data.luma >= 24'(k * LUMA_STEP)) begin
        idx = idx + 4'd1;
      end
    end
    glyph_nxt = s3_data.is_edge ? s3_data.edge_glyph : ramp_char(idx);
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s3_ready) begin
      valid_r <= s3_valid;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      glyph_r <= glyph_nxt;
      red_r   <= s3_data.red;
      green_r <= s3_data.green;
      blue_r  <= s3_data.blue;
    end
  end

  assign out_res.valid     = valid_r;
  assign out_res.glyph     = glyph_r;
  assign out_res.red_out   = red_r;
  assign out_res.green_out = green_r;
  assign out_res.blue_out  = blue_r;

endmodule
`default_nettype wire

// File: src/pixel_to_ascii_glyph.sv
// Pixel to ASCII-art glyph converter: top level with configuration registers
//
// Usage:
//   in_pix  : one pixel word per handshake (RGB plus horizontal and vertical
//             gradients); taken on a clk edge with valid and ready both high.
//   out_res : one result word per pixel (glyph code and brightened RGB), in
//             input order.
//   cfg_*   : write port; index 0 is the Q4.8 gain, index 1 the edge
//             threshold, other indexes are ignored. Write only when idle.
// Pipeline: four register stages (gain/squares, edge test/luma weights, luma
//   sum, ramp lookup with output register).
// Throughput: one pixel per clock, set by the stage-to-stage valid/ready
//   chain; every stage advances each cycle its successor can take data.
// Reset (rst_n low, synchronous): all stage valid bits clear, gain and
//   threshold return to 256.
// Receiver stall: the output register holds its word; earlier stages keep
//   filling empty slots, and in_pix.ready drops once all four are full.
`default_nettype none
`include "assert_macros.svh"
module pixel_to_ascii_glyph import pta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  pta_in_if.sink           in_pix,
  pta_out_if.source        out_res
);

  logic [11:0] gain_r;
  logic [11:0] thresh_r;
  logic        s1_valid;
  s1_t         s1_data;
  logic        s1_ready;
  logic        s3_valid;
  s3_t         s3_data;
  logic        s3_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_GAIN:   gain_r   <= cfg_wdata;
        REG_THRESH: thresh_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  pta_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .gain     (gain_r),
    .thresh   (thresh_r),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  pta_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready),
    .s3_valid (s3_valid),
    .s3_data  (s3_data),
    .s3_ready (s3_ready)
  );

  pta_glyph_out u_glyph_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (s3_valid),
    .s3_data  (s3_data),
    .s3_ready (s3_ready),
    .out_res  (out_res)
  );

  // Checks
  `PTA_ASSERT(a_ready_when_out_empty, !out_res.valid |-> in_pix.ready, "input stalled with empty output")
  `PTA_ASSERT(a_word_emerges, (in_pix.valid && in_pix.ready) ##1 out_res.ready ##1 out_res.ready ##1 out_res.ready |=> out_res.valid, "accepted word did not reach output")
  `PTA_ASSERT_NEVER(a_stall_backpressure, s3_valid && !s3_ready && s1_valid && s1_ready && !out_res.valid, "stage 3 blocked with empty output")

endmodule
`default_nettype wire
